/* rtl/core/sobel_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sobel_pkg
// Shared constants for the streaming 3x3 Sobel edge magnitude block.
// ============================================================================
package sobel_pkg;

    // Grayscale sample width and the clamp limit of the result.
    localparam int PIX_W     = 8;
    localparam int EDGE_MAX  = 255;

    // Sobel sums stay within +/-1020, so 12 signed bits are enough.
    localparam int SUM_W     = 12;

    // Configuration register fields.
    localparam int CFG_W     = 13;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int ROW_W     = 12;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;
    localparam int MIN_DIM       = 3;
    localparam int WIDTH_RST     = 640;
    localparam int HEIGHT_RST    = 480;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

/* rtl/core/sobel_edge_magnitude.sv */
`timescale 1ns / 1ps
// ============================================================================
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude over a raster-order grayscale image.
// ============================================================================
// Usage:
//   The s_ channel takes one pixel per item in raster order; s_frame_start
//   marks row 0, column 0 of a frame. Every accepted item gives exactly one
//   result item on the m_ channel: |Gx|+|Gy|, clamped to 255, of the pixel
//   one row and one column behind the newest input, and 0 on frame borders.
//   m_out_valid is low for the first width+1 results of each frame.
//   An item goes through the stage 1 and result registers to m_valid; with
//   no stall, throughput is one item per cycle, set by the two line memories,
//   which are each read and written once per item. A write and a read of the
//   same column in one cycle are forwarded around the memory.
//   When the receiver stalls, the result register and the stage ahead of it
//   fill and s_ready drops; nothing is lost.
//   Reset clears the counters and window and sets the frame to 640x480. The
//   line memories are not cleared: they only feed border centres until
//   written. The user must write frame size via cfg_we/cfg_index/cfg_wdata
//   only while the block is idle; the block itself does not enforce this.
// ============================================================================
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [sobel_pkg::CFG_W-1:0] cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sobel_pkg::PIX_W-1:0] s_pixel,
    input  logic                        s_frame_start,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sobel_pkg::PIX_W-1:0] m_edge_res,
    output logic                        m_out_valid
);

    import sobel_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int EFFW_W = $clog2(MAX_WIDTH + 1);
    localparam int WIDE_W = 15;
    localparam int WIDTH_RST_SAT = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    // Effective frame size, saturated when written.
    logic [EFFW_W-1:0]   eff_w_reg;
    logic [HEIGHT_W-1:0] eff_h_reg;
    logic [WIDTH_W-1:0]  w_raw;
    logic [HEIGHT_W-1:0] h_raw;
    logic [EFFW_W-1:0]   eff_w_next;
    logic [HEIGHT_W-1:0] eff_h_next;

    // Position counters of the next input.
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage 1: item waiting for its line memory read.
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [PIX_W-1:0] s1_bot_reg;
    logic             s1_border_reg;
    logic             s1_fvalid_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_mid_reg;
    logic [PIX_W-1:0] fwd_top_reg;

    // Line memories: previous row and the row before it.
    logic [PIX_W-1:0] mem_mid [MAX_WIDTH];
    logic [PIX_W-1:0] mem_top [MAX_WIDTH];
    logic [PIX_W-1:0] rd_mid_reg;
    logic [PIX_W-1:0] rd_top_reg;

    // Two previous window columns: 0..2 is c-2, 3..5 is c-1.
    logic [PIX_W-1:0] win_reg [6];

    // Result register.
    logic             m_valid_reg;
    logic [PIX_W-1:0] m_edge_reg;
    logic             m_fvalid_reg;

    logic             s_accept;
    logic             s1_adv;

    logic [COL_W-1:0]    c_start;
    logic [ROW_W-1:0]    r_start;
    logic                col_wrap;
    logic [HEIGHT_W-1:0] row_t;
    logic [COL_W-1:0]    c_cur;
    logic [ROW_W-1:0]    r_cur;
    logic [EFFW_W-1:0]   c_inc;
    logic [HEIGHT_W-1:0] r_inc;
    logic                item_valid;
    logic                item_border;

    logic [PIX_W-1:0]    mid_eff;
    logic [PIX_W-1:0]    top_eff;
    logic signed [SUM_W-1:0] sx, sy, ax, ay, mag_sum;
    logic [PIX_W-1:0]    edge_val;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign w_raw = cfg_wdata[WIDTH_W-1:0];
    assign h_raw = cfg_wdata[HEIGHT_W-1:0];

    always_comb begin
        if (w_raw < WIDTH_W'(MIN_DIM)) begin
            eff_w_next = EFFW_W'(MIN_DIM);
        end else if (WIDE_W'(w_raw) > WIDE_W'(MAX_WIDTH)) begin
            eff_w_next = EFFW_W'(MAX_WIDTH);
        end else begin
            eff_w_next = EFFW_W'(w_raw);
        end
        if (h_raw < HEIGHT_W'(MIN_DIM)) begin
            eff_h_next = HEIGHT_W'(MIN_DIM);
        end else if (h_raw > HEIGHT_W'(MAX_HEIGHT)) begin
            eff_h_next = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            eff_h_next = h_raw;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_w_reg <= EFFW_W'(WIDTH_RST_SAT);
            eff_h_reg <= HEIGHT_W'(HEIGHT_RST);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  eff_w_reg <= eff_w_next;
                REG_FRAME_HEIGHT: eff_h_reg <= eff_h_next;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Position of the incoming item and of the next one
    // ------------------------------------------------------------------
    always_comb begin
        c_start  = s_frame_start ? '0 : col_reg;
        r_start  = s_frame_start ? '0 : row_reg;
        // A count left beyond a narrowed frame wraps before use.
        col_wrap = (EFFW_W'(c_start) >= eff_w_reg);
        row_t    = col_wrap ? (HEIGHT_W'(r_start) + HEIGHT_W'(1)) : HEIGHT_W'(r_start);
        c_cur    = col_wrap ? '0 : c_start;
        r_cur    = (row_t >= eff_h_reg) ? '0 : row_t[ROW_W-1:0];

        c_inc = EFFW_W'(c_cur) + EFFW_W'(1);
        r_inc = HEIGHT_W'(r_cur) + HEIGHT_W'(1);
        if (c_inc >= eff_w_reg) begin
            col_next = '0;
            row_next = (r_inc >= eff_h_reg) ? '0 : r_inc[ROW_W-1:0];
        end else begin
            col_next = c_inc[COL_W-1:0];
            row_next = r_cur;
        end

        // The centre trails by one row and one column. Its column is on the
        // border when the input is in column 0 or 1, and its row is the top
        // border when the input is in row 1.
        item_valid  = (r_cur >= ROW_W'(2)) || (r_cur == ROW_W'(1) && c_cur != '0);
        item_border = !item_valid || (c_cur < COL_W'(2)) || (r_cur == ROW_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers and forwarding
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_addr_reg   <= c_cur;
            s1_bot_reg    <= s_pixel;
            s1_border_reg <= item_border;
            s1_fvalid_reg <= item_valid;
            // The memory read below misses a write to the same column made
            // at this edge, so the values being written are kept aside.
            fwd_reg       <= s1_adv && (s1_addr_reg == c_cur);
            fwd_mid_reg   <= s1_bot_reg;
            fwd_top_reg   <= mid_eff;
        end
    end

    assign mid_eff = fwd_reg ? fwd_mid_reg : rd_mid_reg;
    assign top_eff = fwd_reg ? fwd_top_reg : rd_top_reg;

    // ------------------------------------------------------------------
    // Line memories
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            mem_mid[s1_addr_reg] <= s1_bot_reg;
        end
        if (s_accept) begin
            rd_mid_reg <= mem_mid[c_cur];
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            mem_top[s1_addr_reg] <= mid_eff;
        end
        if (s_accept) begin
            rd_top_reg <= mem_top[c_cur];
        end
    end

    // ------------------------------------------------------------------
    // Window and Sobel arithmetic
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (s1_adv) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_eff;
            win_reg[4] <= mid_eff;
            win_reg[5] <= s1_bot_reg;
        end
    end

    always_comb begin
        sx = - $signed(SUM_W'(win_reg[0])) + $signed(SUM_W'(top_eff))
             - ($signed(SUM_W'(win_reg[1])) <<< 1) + ($signed(SUM_W'(mid_eff)) <<< 1)
             - $signed(SUM_W'(win_reg[2])) + $signed(SUM_W'(s1_bot_reg));
        sy = $signed(SUM_W'(win_reg[0])) + ($signed(SUM_W'(win_reg[3])) <<< 1)
             + $signed(SUM_W'(top_eff)) - $signed(SUM_W'(win_reg[2]))
             - ($signed(SUM_W'(win_reg[5])) <<< 1) - $signed(SUM_W'(s1_bot_reg));
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        mag_sum = ax + ay;
        if (s1_border_reg) begin
            edge_val = '0;
        end else if (mag_sum > SUM_W'(EDGE_MAX)) begin
            edge_val = PIX_W'(EDGE_MAX);
        end else begin
            edge_val = mag_sum[PIX_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_edge_reg   <= edge_val;
            m_fvalid_reg <= s1_fvalid_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_edge_res  = m_edge_reg;
    assign m_out_valid = m_fvalid_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking testbench for sobel_edge_magnitude. Pixels are streamed in
// raster order under random source gaps and sink stalls. A behavioral model
// of the line buffers, window and counters predicts one edge result per
// accepted pixel, and each result is compared with the oldest prediction.
// ============================================================================
module tb_top;
    import sobel_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0] edge_res;
        logic             out_valid;
    } edge_result_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [PIX_W-1:0]     s_pixel = '0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [PIX_W-1:0]     m_edge_res;
    logic                 m_out_valid;

    sobel_edge_magnitude u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_res    (m_edge_res),
        .m_out_valid   (m_out_valid)
    );

    // Model state of the edge filter.
    logic [PIX_W-1:0] prev_row  [MAX_WIDTH_DEF];
    logic [PIX_W-1:0] older_row [MAX_WIDTH_DEF];
    int               win_px [6];
    int               col_cnt;
    int               row_cnt;
    int               frame_w_reg;
    int               frame_h_reg;

    edge_result_t     pending_edges [$];
    edge_result_t     oldest_edge;
    int               mismatch_count;
    int               pixels_sent;
    int               smooth_base;
    bit               gaps_on;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int clamp_dim(input int v, input int hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advances the model by one pixel and returns the edge result it causes.
    function automatic edge_result_t compute_edge(input logic [PIX_W-1:0] pix,
                                                  input logic fs);
        int w, h, c, r, cr, cc;
        int top, mid, bot, gx, gy, sum;
        bit ok, on_border;
        edge_result_t res;
        w = clamp_dim(frame_w_reg, MAX_WIDTH_DEF);
        h = clamp_dim(frame_h_reg, MAX_HEIGHT);
        if (fs) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt++;
        end
        if (row_cnt >= h) row_cnt = 0;
        c = col_cnt;
        r = row_cnt;

        bot = int'(pix);
        mid = int'(prev_row[c]);
        top = int'(older_row[c]);
        older_row[c] = prev_row[c];
        prev_row[c] = pix;

        ok = (r >= 2) || (r == 1 && c >= 1);
        if (c >= 1) begin
            cr = r - 1;
            cc = c - 1;
        end else begin
            // Column 0 closes the last column of the row two rows up.
            cr = r - 2;
            cc = w - 1;
        end
        on_border = !ok || cr == 0 || cr == h - 1 || cc == 0 || cc == w - 1;

        sum = 0;
        if (!on_border) begin
            gx = -win_px[0] + top - 2 * win_px[1] + 2 * mid - win_px[2] + bot;
            gy = win_px[0] + 2 * win_px[3] + top - win_px[2] - 2 * win_px[5] - bot;
            sum = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            if (sum > EDGE_MAX) sum = EDGE_MAX;
        end

        win_px[0] = win_px[3];
        win_px[1] = win_px[4];
        win_px[2] = win_px[5];
        win_px[3] = top;
        win_px[4] = mid;
        win_px[5] = bot;

        col_cnt = c + 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            row_cnt = r + 1;
            if (row_cnt >= h) row_cnt = 0;
        end

        res.edge_res  = PIX_W'(sum);
        res.out_valid = ok;
        return res;
    endfunction

    // Sends one pixel item; called right after a rising edge.
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        if (gaps_on && $urandom_range(99) < 8) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel       <= pix;
        s_frame_start <= fs;
        do @(posedge aclk); while (!(s_valid && s_ready));
        pending_edges.push_back(compute_edge(pix, fs));
        pixels_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_WIDTH) frame_w_reg = int'(val[WIDTH_W-1:0]);
        else frame_h_reg = int'(val[HEIGHT_W-1:0]);
    endtask

    function automatic logic [PIX_W-1:0] pick_pixel(input int mode);
        case (mode)
            0: return PIX_W'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return PIX_W'(smooth_base + $urandom_range(0, 6));
        endcase
    endfunction

    // Small frames with full-scale steps and signed gradients.
    task automatic test_directed_extremes();
        int i;
        // Reset size is 640 wide, so these are all start-of-frame results.
        for (i = 0; i < 3; i++) send_pixel(8'(i * 255 / 2), i == 0);
        // Upper bits of the width write lie outside the register.
        write_reg(REG_FRAME_WIDTH, 13'h1803);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'hFF : 8'h00, i == 0);
        // Sizes below the minimum behave as 3x3; this frame starts by wrapping.
        write_reg(REG_FRAME_WIDTH, 13'd0);
        write_reg(REG_FRAME_HEIGHT, 13'd1);
        for (i = 0; i < 9; i++) send_pixel(8'(14 - 2 * (i % 3) + 10 * (i / 3)), 1'b0);
    endtask

    // The all-ones width saturates to a wide row, so the first row runs well
    // past the small sizes; the frame is then narrowed under the running column.
    task automatic test_wide_rows();
        int i;
        write_reg(REG_FRAME_WIDTH, 13'h07FF);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (i = 0; i < 64; i++) send_pixel(pick_pixel(0), i == 0);
        write_reg(REG_FRAME_WIDTH, 13'd24);
        for (i = 0; i < 3 * 24; i++) send_pixel(pick_pixel(0), 1'b0);
    endtask

    task automatic test_tall_frames();
        int i;
        write_reg(REG_FRAME_WIDTH, 13'd2);
        write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
        for (i = 0; i < 36; i++) send_pixel(pick_pixel(i % 2), i == 0);
        write_reg(REG_FRAME_HEIGHT, 13'h1000);
        for (i = 0; i < 12; i++) send_pixel(pick_pixel(0), 1'b0);
    endtask

    // Shrinks the frame under the running counters.
    task automatic test_counter_wrap();
        int i;
        write_reg(REG_FRAME_WIDTH, 13'd8);
        write_reg(REG_FRAME_HEIGHT, 13'd6);
        for (i = 0; i < 30; i++) send_pixel(pick_pixel(0), i == 0);
        write_reg(REG_FRAME_WIDTH, 13'd4);
        for (i = 0; i < 10; i++) send_pixel(pick_pixel(0), 1'b0);
        write_reg(REG_FRAME_HEIGHT, 13'd3);
        for (i = 0; i < 12; i++) send_pixel(pick_pixel(0), 1'b0);
    endtask

    // Full rate on both sides; the second frame begins without a start flag.
    task automatic test_back_to_back();
        int i;
        write_reg(REG_FRAME_WIDTH, 13'd10);
        write_reg(REG_FRAME_HEIGHT, 13'd5);
        gaps_on = 1'b0;
        for (i = 0; i < 100; i++) send_pixel(pick_pixel(0), i == 0);
        wait_results_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_frames();
        int w, h, nframes, npix, mode, first_count, f, i;
        bit fs;
        first_count = pixels_sent;
        while (pixels_sent - first_count < 340) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            if ($urandom_range(99) < 10) w = $urandom_range(0, 2);
            if ($urandom_range(99) < 10) h = $urandom_range(0, 2);
            write_reg(REG_FRAME_WIDTH, CFG_W'(w));
            write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
            w = clamp_dim(w, MAX_WIDTH_DEF);
            h = clamp_dim(h, MAX_HEIGHT);
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++) begin
                mode = $urandom_range(0, 2);
                smooth_base = $urandom_range(0, 249);
                npix = w * h;
                // Some frames are cut short; the next one restarts them only when it carries a start flag.
                if ($urandom_range(99) < 15) npix = $urandom_range(1, w * h - 1);
                for (i = 0; i < npix; i++) begin
                    fs = (i == 0) && (f == 0 || $urandom_range(99) < 70);
                    if (i != 0 && $urandom_range(999) < 5) fs = 1'b1;
                    send_pixel(pick_pixel(mode), fs);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(99) >= 12);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_edges.size() == 0) begin
                report_mismatch("edge result with no pixel pending");
            end else begin
                oldest_edge = pending_edges.pop_front();
                if (m_edge_res !== oldest_edge.edge_res)
                    report_mismatch($sformatf("edge_res %0d, predicted %0d",
                                              m_edge_res, oldest_edge.edge_res));
                if (m_out_valid !== oldest_edge.out_valid)
                    report_mismatch($sformatf("out_valid %0b, predicted %0b",
                                              m_out_valid, oldest_edge.out_valid));
            end
        end
    end

    initial begin
        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            prev_row[i]  = '0;
            older_row[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_px[i] = 0;
        col_cnt        = 0;
        row_cnt        = 0;
        frame_w_reg    = WIDTH_RST;
        frame_h_reg    = HEIGHT_RST;
        mismatch_count = 0;
        pixels_sent    = 0;
        smooth_base    = 0;
        gaps_on        = 1'b1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_extremes();
        test_wide_rows();
        test_tall_frames();
        test_counter_wrap();
        test_back_to_back();
        test_random_frames();

        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
